// File: rtl/bhls_pkg.sv
// Package for the byte histogram with line statistics.
// Request and result payload types, table entry layout, opcodes and helpers.
// No dependencies.
package bhls_pkg;

    localparam int COUNT_BITS = 32;
    localparam int BYTE_BITS  = 8;
    localparam int TABLE_DEPTH = 256;

    localparam logic [BYTE_BITS-1:0] NEWLINE_BYTE = 8'h0A;

    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        OP_COUNT   = 2'd0,
        OP_READ    = 2'd1,
        OP_SUMMARY = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                  operation;
        logic [BYTE_BITS-1:0] data_byte;
    } req_t;

    typedef struct packed {
        logic                  result_kind;
        logic [BYTE_BITS-1:0]  entry_index;
        logic [COUNT_BITS-1:0] occurrences;
        logic                  seen_flag;
        logic [COUNT_BITS-1:0] first_line;
        logic [COUNT_BITS-1:0] last_line;
        logic [COUNT_BITS-1:0] total_bytes;
        logic [COUNT_BITS-1:0] line_total;
        logic [COUNT_BITS-1:0] longest_length;
        logic [COUNT_BITS-1:0] longest_line_number;
    } rsp_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] first_line;
        logic [COUNT_BITS-1:0] last_line;
    } entry_t;

    // increment, holding at all ones
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

endpackage

// File: rtl/bhls_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bhls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/byte_histogram_line_stats.sv
// Top level of the byte histogram with line statistics.
// Depends on bhls_pkg and bhls_ram (entry table storage).
//
// Usage:
//   Requests arrive on req (req_valid/req_ready): count a byte, read one
//   table entry, read the summary, or clear the table. Only the two read
//   requests give a result, on rsp (rsp_valid/rsp_ready).
//   The entry table (count, first line, last line) sits in a 256 x 96 RAM
//   with registered read data; valid marks are 256 flops.
//   A request is accepted and its entry read in the first stage; in the
//   second stage the entry is modified and written back, or the result is
//   loaded into the output register. One request per cycle is taken
//   unless a read waits on a stalled receiver. Back-to-back counts of the
//   same byte are served by forwarding the entry just written.
//   A stalled receiver holds the output register; one further read request
//   may wait in the second stage, then req_ready drops. Counts and clears
//   never wait on the receiver unless a read is queued ahead of them.
//   Reset clears the valid marks, totals and line state at once (line 1);
//   no clearing pass is needed. A clear request drops only valid marks.
module byte_histogram_line_stats (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  bhls_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bhls_pkg::rsp_t rsp
);

    logic                              s1_valid_reg, s1_valid_next;
    bhls_pkg::req_t                    s1_req_reg;
    logic                              hit_reg;
    bhls_pkg::entry_t                  fwd_reg;
    logic [bhls_pkg::TABLE_DEPTH-1:0]  valid_reg, valid_next;
    logic [bhls_pkg::COUNT_BITS-1:0]   total_reg, total_next;
    logic [bhls_pkg::COUNT_BITS-1:0]   line_reg, line_next;
    logic [bhls_pkg::COUNT_BITS-1:0]   cur_len_reg, cur_len_next;
    logic [bhls_pkg::COUNT_BITS-1:0]   max_len_reg, max_len_next;
    logic [bhls_pkg::COUNT_BITS-1:0]   max_line_reg, max_line_next;
    logic                              rsp_valid_reg, rsp_valid_next;
    bhls_pkg::rsp_t                    rsp_reg, rsp_next;

    logic                              req_accept;
    logic                              out_free;
    logic                              s1_is_read;
    logic                              s1_go;
    logic                              seen;
    bhls_pkg::entry_t                  rd_entry;
    bhls_pkg::entry_t                  ent;
    bhls_pkg::entry_t                  wr_entry;
    logic                              wr_en;

    bhls_ram #(
        .WIDTH ($bits(bhls_pkg::entry_t)),
        .DEPTH (bhls_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_req_reg.data_byte),
        .wr_data (wr_entry),
        .rd_en   (req_accept),
        .rd_addr (req.data_byte),
        .rd_data (rd_entry)
    );

    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign s1_is_read = (s1_req_reg.operation == bhls_pkg::OP_READ)
                     || (s1_req_reg.operation == bhls_pkg::OP_SUMMARY);
    assign s1_go      = s1_valid_reg && (!s1_is_read || out_free);
    assign req_ready  = !s1_valid_reg || s1_go;
    assign req_accept = req_valid && req_ready;

    assign ent  = hit_reg ? fwd_reg : rd_entry;
    assign seen = valid_reg[s1_req_reg.data_byte];

    always_comb
    begin
        wr_entry.count      = seen ? bhls_pkg::sat_inc(ent.count) : bhls_pkg::COUNT_BITS'(1);
        wr_entry.first_line = seen ? ent.first_line : line_reg;
        wr_entry.last_line  = line_reg;
        wr_en = s1_go && (s1_req_reg.operation == bhls_pkg::OP_COUNT);
    end

    always_comb
    begin
        s1_valid_next  = req_accept || (s1_valid_reg && !s1_go);
        valid_next     = valid_reg;
        total_next     = total_reg;
        line_next      = line_reg;
        cur_len_next   = cur_len_reg;
        max_len_next   = max_len_reg;
        max_line_next  = max_line_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        if (s1_go)
        begin
            unique case (s1_req_reg.operation)
                bhls_pkg::OP_COUNT:
                begin
                    valid_next[s1_req_reg.data_byte] = 1'b1;
                    total_next = bhls_pkg::sat_inc(total_reg);
                    if (s1_req_reg.data_byte != bhls_pkg::NEWLINE_BYTE)
                    begin
                        cur_len_next = bhls_pkg::sat_inc(cur_len_reg);
                    end
                    else
                    begin
                        if (cur_len_reg > max_len_reg)
                        begin
                            max_len_next  = cur_len_reg;
                            max_line_next = line_reg;
                        end
                        line_next    = bhls_pkg::sat_inc(line_reg);
                        cur_len_next = '0;
                    end
                end
                bhls_pkg::OP_CLEAR:
                begin
                    valid_next = '0;
                end
                bhls_pkg::OP_READ:
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next             = '0;
                    rsp_next.result_kind = bhls_pkg::KIND_ENTRY;
                    rsp_next.entry_index = s1_req_reg.data_byte;
                    if (seen)
                    begin
                        rsp_next.occurrences = ent.count;
                        rsp_next.seen_flag   = 1'b1;
                        rsp_next.first_line  = ent.first_line;
                        rsp_next.last_line   = ent.last_line;
                    end
                end
                bhls_pkg::OP_SUMMARY:
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next             = '0;
                    rsp_next.result_kind = bhls_pkg::KIND_SUMMARY;
                    rsp_next.total_bytes = total_reg;
                    rsp_next.line_total  = line_reg;
                    // unfinished last line counts towards the longest
                    if (cur_len_reg > max_len_reg)
                    begin
                        rsp_next.longest_length      = cur_len_reg;
                        rsp_next.longest_line_number = line_reg;
                    end
                    else
                    begin
                        rsp_next.longest_length      = max_len_reg;
                        rsp_next.longest_line_number = max_line_reg;
                    end
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            valid_reg     <= '0;
            total_reg     <= '0;
            line_reg      <= bhls_pkg::COUNT_BITS'(1);
            cur_len_reg   <= '0;
            max_len_reg   <= '0;
            max_line_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            valid_reg     <= valid_next;
            total_reg     <= total_next;
            line_reg      <= line_next;
            cur_len_reg   <= cur_len_next;
            max_len_reg   <= max_len_next;
            max_line_reg  <= max_line_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers; forward capture only when a new request enters
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (req_accept)
        begin
            s1_req_reg <= req;
            hit_reg    <= wr_en && (s1_req_reg.data_byte == req.data_byte);
            fwd_reg    <= wr_entry;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && (s1_req_reg.operation == bhls_pkg::OP_CLEAR) |=> (valid_reg == '0))
        else $error("valid marks not cleared after clear request");

    a_count_marks: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> valid_reg[$past(s1_req_reg.data_byte)])
        else $error("counted byte not marked valid");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.result_kind == bhls_pkg::KIND_SUMMARY) |-> (rsp.line_total != '0))
        else $error("summary reports line zero");

    a_unseen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.result_kind == bhls_pkg::KIND_ENTRY) && !rsp.seen_flag
        |-> (rsp.occurrences == '0) && (rsp.first_line == '0) && (rsp.last_line == '0))
        else $error("unseen entry reports non-zero fields");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> s1_valid_reg && s1_is_read && rsp_valid_reg && !rsp_ready)
        else $error("request stalled without a blocked result");

endmodule

// File: bench/tb_top.sv
// Testbench for byte_histogram_line_stats: a built-in predictor of the histogram and
// line statistics, random sender and receiver gaps, and a long receiver hold-off.
// Depends on bhls_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
    import bhls_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // predictor state
    logic [31:0] occ_tab [256];
    logic [31:0] first_tab [256];
    logic [31:0] last_tab [256];
    bit          seen_tab [256];
    logic [31:0] byte_count;
    logic [31:0] line_no;
    logic [31:0] cur_len;
    logic [31:0] max_len;
    logic [31:0] max_len_line;

    rsp_t pending_results [$];
    int   errors;
    int   idle_cycles;
    bit   quiet;
    int   hold_cycles;

    byte_histogram_line_stats i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic tally_request(input req_t r);
        rsp_t        res;
        logic [7:0]  b;
        b = r.data_byte;
        res = '0;
        case (r.operation)
            OP_COUNT:
            begin
                byte_count = bump(byte_count);
                if (seen_tab[b])
                begin
                    occ_tab[b] = bump(occ_tab[b]);
                end
                else
                begin
                    occ_tab[b] = 32'd1;
                    first_tab[b] = line_no;
                    seen_tab[b] = 1'b1;
                end
                last_tab[b] = line_no;
                if (b != NEWLINE_BYTE)
                begin
                    cur_len = bump(cur_len);
                end
                else
                begin
                    if (cur_len > max_len)
                    begin
                        max_len = cur_len;
                        max_len_line = line_no;
                    end
                    line_no = bump(line_no);
                    cur_len = '0;
                end
            end
            OP_CLEAR:
            begin
                foreach (seen_tab[i])
                    seen_tab[i] = 1'b0;
            end
            OP_READ:
            begin
                res.result_kind = KIND_ENTRY;
                res.entry_index = b;
                if (seen_tab[b])
                begin
                    res.occurrences = occ_tab[b];
                    res.seen_flag = 1'b1;
                    res.first_line = first_tab[b];
                    res.last_line = last_tab[b];
                end
                pending_results.push_back(res);
            end
            OP_SUMMARY:
            begin
                res.result_kind = KIND_SUMMARY;
                res.total_bytes = byte_count;
                res.line_total = line_no;
                // unfinished last line counts towards the longest line
                res.longest_length = (cur_len > max_len) ? cur_len : max_len;
                res.longest_line_number = (cur_len > max_len) ? line_no : max_len_line;
                pending_results.push_back(res);
            end
        endcase
    endtask

    task automatic send_request(input op_t op, input logic [7:0] b);
        req_t r;
        int   gap;
        r.operation = op;
        r.data_byte = b;
        gap = quiet ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
        tally_request(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // receiver: per result stall, or a long hold-off when one is requested
    initial
    begin
        int stall;
        rsp_ready = 1'b0;
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                stall = quiet ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0)
            begin
                @(negedge clk);
                rsp_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!(rsp_valid && rsp_ready));
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", want.result_kind, rsp.result_kind);
                check_field("entry_index", want.entry_index, rsp.entry_index);
                check_field("occurrences", want.occurrences, rsp.occurrences);
                check_field("seen_flag", want.seen_flag, rsp.seen_flag);
                check_field("first_line", want.first_line, rsp.first_line);
                check_field("last_line", want.last_line, rsp.last_line);
                check_field("total_bytes", want.total_bytes, rsp.total_bytes);
                check_field("line_total", want.line_total, rsp.line_total);
                check_field("longest_length", want.longest_length, rsp.longest_length);
                check_field("longest_line_number", want.longest_line_number,
                            rsp.longest_line_number);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 1000)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_request(OP_SUMMARY, 8'h00);
        send_request(OP_READ, 8'h00);
        send_request(OP_READ, 8'hFF);
        send_request(OP_COUNT, 8'h00);
        send_request(OP_COUNT, 8'hFF);
        // newline seen for the first time records the line it ends
        send_request(OP_COUNT, NEWLINE_BYTE);
        send_request(OP_COUNT, 8'h61);
        send_request(OP_COUNT, 8'h61);
        send_request(OP_COUNT, 8'h61);
        send_request(OP_READ, 8'h61);
        send_request(OP_READ, NEWLINE_BYTE);
        send_request(OP_READ, 8'hFF);
        send_request(OP_SUMMARY, 8'hFF);
        send_request(OP_COUNT, NEWLINE_BYTE);
        send_request(OP_COUNT, NEWLINE_BYTE);
        send_request(OP_SUMMARY, 8'h00);
        send_request(OP_CLEAR, 8'hFF);
        send_request(OP_READ, 8'h61);
        send_request(OP_SUMMARY, 8'h00);
        send_request(OP_COUNT, 8'h61);
        send_request(OP_READ, 8'h61);
        send_request(OP_READ, 8'h00);
        send_request(OP_SUMMARY, 8'h00);
    endtask

    // lines of text with reads, summaries and the odd clear mixed in
    task automatic test_text_stream(input int n_items);
        int         sent;
        int         len;
        int         pick;
        logic [7:0] recent;
        sent = 0;
        recent = 8'h20;
        while (sent < n_items)
        begin
            if (sent % 100 < 5)
                quiet = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 9);
            len = (pick == 0) ? 0 : (pick == 9) ? $urandom_range(20, 90)
                                                : $urandom_range(1, 12);
            repeat (len)
            begin
                recent = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(8'h20, 8'h7E));
                send_request(OP_COUNT, recent);
                sent++;
                pick = $urandom_range(0, 19);
                if (pick < 4)
                begin
                    send_request(OP_READ, (pick < 2) ? recent : 8'($urandom_range(0, 255)));
                    sent++;
                end
                else if (pick == 4)
                begin
                    send_request(OP_SUMMARY, 8'($urandom_range(0, 255)));
                    sent++;
                end
            end
            send_request(OP_COUNT, NEWLINE_BYTE);
            send_request(OP_SUMMARY, 8'($urandom_range(0, 255)));
            sent += 2;
            if ($urandom_range(0, 24) == 0)
            begin
                send_request(OP_CLEAR, 8'($urandom_range(0, 255)));
                sent++;
            end
        end
        quiet = 1'b0;
    endtask

    task automatic test_noise(input int n_items);
        repeat (n_items)
            send_request(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    // receiver holds off while reads keep coming, so the input stalls
    task automatic test_backpressure();
        quiet = 1'b1;
        hold_cycles = 80;
        repeat (40)
        begin
            case ($urandom_range(0, 2))
                0: send_request(OP_READ, 8'($urandom_range(0, 255)));
                1: send_request(OP_SUMMARY, 8'h00);
                default: send_request(OP_COUNT, 8'($urandom_range(0, 255)));
            endcase
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        errors = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        hold_cycles = 0;
        foreach (seen_tab[i])
            seen_tab[i] = 1'b0;
        byte_count = '0;
        line_no = 32'd1;
        cur_len = '0;
        max_len = '0;
        max_len_line = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_text_stream(1250);
        test_noise(150);
        test_backpressure();

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: byte_histogram_line_stats.f
rtl/bhls_pkg.sv
rtl/bhls_ram.sv
rtl/byte_histogram_line_stats.sv
bench/tb_top.sv
